FILE: rtl/midi_track_event_parser_defines.svh
// assertion macros for the track parser checker
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

`define MTP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define MTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/mtep_pkg.sv
package mtep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [31:0] tick;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [7:0]  meta_type;
    logic [31:0] length_value;
    logic [7:0]  payload_byte;
    logic        last_of_payload;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_SEARCH    = 5'd0,
    PH_LEN0      = 5'd1,
    PH_LEN1      = 5'd2,
    PH_LEN2      = 5'd3,
    PH_LEN3      = 5'd4,
    PH_DELTA     = 5'd5,
    PH_STATUS    = 5'd6,
    PH_CH_D1     = 5'd7,
    PH_CH_D2     = 5'd8,
    PH_META_TYPE = 5'd9,
    PH_META_LEN  = 5'd10,
    PH_EOT_SKIP  = 5'd11,
    PH_SYSEX_LEN = 5'd12,
    PH_F7_NEXT   = 5'd13,
    PH_PAYLOAD   = 5'd14,
    PH_SC_D1     = 5'd15,
    PH_SC_D2     = 5'd16
  } phase_t;

  localparam logic [3:0] EV_START   = 4'd0;
  localparam logic [3:0] EV_CHANNEL = 4'd1;
  localparam logic [3:0] EV_SYSCOM  = 4'd2;
  localparam logic [3:0] EV_RT      = 4'd3;
  localparam logic [3:0] EV_META    = 4'd4;
  localparam logic [3:0] EV_SYSEX   = 4'd5;
  localparam logic [3:0] EV_PAYLOAD = 4'd6;
  localparam logic [3:0] EV_END     = 4'd7;
  localparam logic [3:0] EV_ERROR   = 4'd8;

  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_F1      = 8'hF1;
  localparam logic [7:0] ST_F2      = 8'hF2;
  localparam logic [7:0] ST_F3      = 8'hF3;
  localparam logic [7:0] ST_F6      = 8'hF6;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;
  localparam logic [7:0] ST_UNDEF   = 8'hFD;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] META_EOT   = 8'h2F;

endpackage

FILE: rtl/mtep_fifo.sv
module mtep_fifo #(
  parameter int Depth = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  mtep_pkg::out_item_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output mtep_pkg::out_item_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  mtep_pkg::out_item_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

FILE: rtl/mtep_front.sv
module mtep_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtep_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output mtep_pkg::in_item_t q_data
);
  // one-deep skid register between input port and the parse core
  mtep_pkg::in_item_t buf_r;
  logic               full_r;

  assign in_ready = !full_r || q_ready;
  assign q_valid  = full_r;
  assign q_data   = buf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ready) begin
      full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) buf_r <= in_data;
  end
endmodule

FILE: rtl/mtep_back.sv
module mtep_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  mtep_pkg::in_item_t  q_data,
  output logic                r_valid,
  input  logic                r_ready,
  output mtep_pkg::out_item_t r_data
);
  mtep_pkg::phase_t ph_r, ph_nxt;
  logic [1:0]  tag_r, tag_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  mt_r, mt_nxt;
  logic [31:0] pay_r, pay_nxt;

  logic                have;
  mtep_pkg::out_item_t res;
  mtep_pkg::out_item_t ob_r;
  logic                ov_r;
  logic                go;
  logic [7:0]          b;
  logic [7:0]          tagc;
  logic [31:0]         left_dec;
  logic [31:0]         dacc;
  logic [31:0]         plen;
  logic [31:0]         pay_dec;
  logic [7:0]          st;

  assign q_ready = !ov_r || r_ready;
  assign go      = q_valid && q_ready;
  assign r_valid = ov_r;
  assign r_data  = ob_r;
  assign b       = q_data.data_byte;
  assign left_dec = left_r - 32'd1;
  assign pay_dec  = pay_r - 32'd1;

  always_comb begin
    case (tag_r)
      2'd0:    tagc = 8'h4D;
      2'd1:    tagc = 8'h54;
      2'd2:    tagc = 8'h72;
      default: tagc = 8'h6B;
    endcase
  end

  always_comb begin
    ph_nxt = ph_r; tag_nxt = tag_r; left_nxt = left_r; tick_nxt = tick_r;
    delta_nxt = delta_r; run_nxt = run_r; cur_nxt = cur_r; held_nxt = held_r;
    mt_nxt = mt_r; pay_nxt = pay_r;
    have = 1'b0; res = '0; dacc = '0; plen = '0; st = '0;
    if (ph_r == mtep_pkg::PH_SEARCH) begin
      if (b == tagc) begin
        if (tag_r == 2'd3) begin
          tag_nxt = 2'd0; left_nxt = '0; ph_nxt = mtep_pkg::PH_LEN0;
        end else begin
          tag_nxt = tag_r + 2'd1;
        end
      end else begin
        tag_nxt = (b == 8'h4D) ? 2'd1 : 2'd0;
      end
    end else if (ph_r inside {[mtep_pkg::PH_LEN0:mtep_pkg::PH_LEN3]}) begin
      left_nxt = {left_r[23:0], b};
      if (ph_r == mtep_pkg::PH_LEN3) begin
        tick_nxt = '0; run_nxt = '0; delta_nxt = '0;
        have = 1'b1; res.event_kind = mtep_pkg::EV_START;
        res.length_value = left_nxt;
        ph_nxt = (left_nxt == '0) ? mtep_pkg::PH_SEARCH : mtep_pkg::PH_DELTA;
      end else begin
        ph_nxt = mtep_pkg::phase_t'(ph_r + 5'd1);
      end
    end else begin
      // inside a track: one byte consumed
      left_nxt = left_dec;
      // "need more" target, resolved below; event done goes to delta
      case (ph_r)
        mtep_pkg::PH_DELTA, mtep_pkg::PH_STATUS, mtep_pkg::PH_CH_D1,
        mtep_pkg::PH_F7_NEXT: begin
          // classify status path
          st = b;
          if (ph_r == mtep_pkg::PH_CH_D1) begin
            st = cur_r;
          end else if (ph_r == mtep_pkg::PH_STATUS && !b[7] &&
                       run_r[7] && run_r[7:4] != 4'hF) begin
            st = run_r;
            cur_nxt = run_r;
          end
          if (ph_r == mtep_pkg::PH_DELTA ||
              (ph_r == mtep_pkg::PH_STATUS && !b[7] &&
               !(run_r[7] && run_r[7:4] != 4'hF))) begin
            dacc = (ph_r == mtep_pkg::PH_DELTA) ? {delta_r[24:0], b[6:0]}
                                                 : {25'd0, b[6:0]};
            delta_nxt = dacc;
            if (b[7]) begin
              ph_nxt = mtep_pkg::PH_DELTA;
            end else begin
              tick_nxt = tick_r + dacc;
              ph_nxt = mtep_pkg::PH_STATUS;
            end
          end else if (ph_r == mtep_pkg::PH_CH_D1 ||
                       (ph_r == mtep_pkg::PH_STATUS && !b[7])) begin
            // channel first data byte
            held_nxt = b;
            if (st[7:4] != 4'hC && st[7:4] != 4'hD) begin
              ph_nxt = mtep_pkg::PH_CH_D2;
            end else begin
              have = 1'b1; res.event_kind = mtep_pkg::EV_CHANNEL;
              res.status_byte = st; res.first_data = b;
              run_nxt = st;
              ph_nxt = mtep_pkg::PH_DELTA;
            end
          end else if (ph_r == mtep_pkg::PH_F7_NEXT && !b[7]) begin
            ph_nxt = mtep_pkg::PH_SEARCH;
          end else begin
            // dispatch of status b
            cur_nxt = b;
            if (b < 8'hF0) begin
              ph_nxt = mtep_pkg::PH_CH_D1;
            end else if (b == mtep_pkg::ST_META) begin
              ph_nxt = mtep_pkg::PH_META_TYPE;
            end else if (b == mtep_pkg::ST_SYSEX) begin
              run_nxt = '0; pay_nxt = '0; ph_nxt = mtep_pkg::PH_SYSEX_LEN;
            end else if (b == mtep_pkg::ST_ESCAPE) begin
              run_nxt = '0; ph_nxt = mtep_pkg::PH_F7_NEXT;
            end else if (b <= mtep_pkg::ST_F6) begin
              run_nxt = '0;
              if (b == mtep_pkg::ST_F1 || b == mtep_pkg::ST_F2 ||
                  b == mtep_pkg::ST_F3) begin
                ph_nxt = mtep_pkg::PH_SC_D1;
              end else begin
                have = 1'b1; res.event_kind = mtep_pkg::EV_SYSCOM;
                res.status_byte = b; ph_nxt = mtep_pkg::PH_DELTA;
              end
            end else begin
              if (b != mtep_pkg::ST_UNDEF) begin
                have = 1'b1; res.event_kind = mtep_pkg::EV_RT;
                res.status_byte = b;
              end
              ph_nxt = mtep_pkg::PH_DELTA;
            end
          end
        end
        mtep_pkg::PH_CH_D2: begin
          have = 1'b1; res.event_kind = mtep_pkg::EV_CHANNEL;
          res.status_byte = cur_r; res.first_data = held_r; res.second_data = b;
          run_nxt = cur_r; ph_nxt = mtep_pkg::PH_DELTA;
        end
        mtep_pkg::PH_META_TYPE: begin
          mt_nxt = b;
          if (b == mtep_pkg::META_EOT) begin
            ph_nxt = mtep_pkg::PH_EOT_SKIP;
          end else begin
            pay_nxt = '0; ph_nxt = mtep_pkg::PH_META_LEN;
          end
        end
        mtep_pkg::PH_EOT_SKIP: begin
          have = 1'b1; res.event_kind = mtep_pkg::EV_END;
          res.status_byte = mtep_pkg::ST_META; res.meta_type = mtep_pkg::META_EOT;
          res.length_value = delta_r; ph_nxt = mtep_pkg::PH_DELTA;
        end
        mtep_pkg::PH_PAYLOAD: begin
          pay_nxt = pay_dec;
          have = 1'b1; res.event_kind = mtep_pkg::EV_PAYLOAD;
          res.status_byte = cur_r;
          res.meta_type = (cur_r == mtep_pkg::ST_META) ? mt_r : 8'h00;
          res.payload_byte = b; res.last_of_payload = (pay_dec == '0);
          ph_nxt = (pay_dec == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
        end
        mtep_pkg::PH_SC_D1: begin
          held_nxt = b;
          if (cur_r == mtep_pkg::ST_F2) begin
            ph_nxt = mtep_pkg::PH_SC_D2;
          end else begin
            have = 1'b1; res.event_kind = mtep_pkg::EV_SYSCOM;
            res.status_byte = cur_r; res.first_data = b;
            ph_nxt = mtep_pkg::PH_DELTA;
          end
        end
        mtep_pkg::PH_SC_D2: begin
          have = 1'b1; res.event_kind = mtep_pkg::EV_SYSCOM;
          res.status_byte = cur_r; res.first_data = held_r; res.second_data = b;
          ph_nxt = mtep_pkg::PH_DELTA;
        end
        default: ph_nxt = mtep_pkg::PH_SEARCH;
      endcase
      // length bytes (meta, sysex, or F7 followed by data)
      if (ph_r == mtep_pkg::PH_META_LEN || ph_r == mtep_pkg::PH_SYSEX_LEN ||
          (ph_r == mtep_pkg::PH_F7_NEXT && !b[7])) begin
        plen = (ph_r == mtep_pkg::PH_F7_NEXT) ? {25'd0, b[6:0]}
                                               : {pay_r[24:0], b[6:0]};
        pay_nxt = plen;
        if (b[7]) begin
          ph_nxt = ph_r;
        end else begin
          have = 1'b1;
          res.event_kind = (ph_r == mtep_pkg::PH_META_LEN) ? mtep_pkg::EV_META
                                                           : mtep_pkg::EV_SYSEX;
          res.status_byte = cur_r;
          res.meta_type = (ph_r == mtep_pkg::PH_META_LEN) ? mt_r : 8'h00;
          res.length_value = plen; res.last_of_payload = (plen == '0);
          ph_nxt = (plen == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
        end
      end
      // event done / need more against remaining track bytes
      if (left_dec == '0) begin
        if (ph_nxt == mtep_pkg::PH_DELTA && have) begin
          ph_nxt = mtep_pkg::PH_SEARCH;
        end else if (ph_nxt == mtep_pkg::PH_DELTA && ph_r inside
                     {mtep_pkg::PH_STATUS, mtep_pkg::PH_F7_NEXT} && b[7] &&
                     b == mtep_pkg::ST_UNDEF) begin
          ph_nxt = mtep_pkg::PH_SEARCH;
        end else begin
          have = 1'b1; res = '0; res.event_kind = mtep_pkg::EV_ERROR;
          ph_nxt = mtep_pkg::PH_SEARCH;
        end
      end else if (ph_nxt == mtep_pkg::PH_DELTA && (have ||
                   ((ph_r == mtep_pkg::PH_STATUS || ph_r == mtep_pkg::PH_F7_NEXT)
                    && b == mtep_pkg::ST_UNDEF))) begin
        delta_nxt = '0;
      end
    end
    if (q_data.stream_end) begin
      if (ph_nxt != mtep_pkg::PH_SEARCH) begin
        have = 1'b1; res = '0; res.event_kind = mtep_pkg::EV_ERROR;
      end
      ph_nxt = mtep_pkg::PH_SEARCH; tag_nxt = '0;
    end
    res.tick = tick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= mtep_pkg::PH_SEARCH; tag_r <= '0; left_r <= '0; tick_r <= '0;
      delta_r <= '0; run_r <= '0; cur_r <= '0; held_r <= '0; mt_r <= '0;
      pay_r <= '0; ov_r <= 1'b0;
    end else begin
      if (go) begin
        ph_r <= ph_nxt; tag_r <= tag_nxt; left_r <= left_nxt; tick_r <= tick_nxt;
        delta_r <= delta_nxt; run_r <= run_nxt; cur_r <= cur_nxt;
        held_r <= held_nxt; mt_r <= mt_nxt; pay_r <= pay_nxt;
      end
      if (q_ready) ov_r <= go && have;
    end
  end

  always_ff @(posedge clk) begin
    if (go && have) ob_r <= res;
  end
endmodule

FILE: rtl/midi_track_event_parser.sv
// an event passes the front register, the parse-core output register and the fifo before out_valid rises
// throughput: one byte per cycle while the output is not stalled; each byte makes one register update in the parse core
// results pass an OutDepth-entry fifo (two by default) so the parser keeps taking bytes while one waits
// reset: synchronous active-low rst_n; parser returns to tag search, queues empty
module midi_track_event_parser #(
  parameter int OutDepth = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtep_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtep_pkg::out_item_t out_data
);
  logic                q_valid, q_ready;
  mtep_pkg::in_item_t  q_data;
  logic                r_valid, r_ready;
  mtep_pkg::out_item_t r_data;

  mtep_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  mtep_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .r_valid, .r_ready, .r_data
  );

  mtep_fifo #(.Depth(OutDepth)) u_fifo (
    .clk, .rst_n,
    .wr_valid(r_valid), .wr_ready(r_ready), .wr_data(r_data),
    .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(out_data)
  );
endmodule

FILE: rtl/mtep_checker.sv
`include "midi_track_event_parser_defines.svh"

module mtep_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mtep_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mtep_pkg::out_item_t out_data
);
  `MTP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_data))
  `MTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `MTP_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_data.event_kind <= mtep_pkg::EV_ERROR)
  `MTP_ASSERT_IMPL(a_err_clean, clk, rst_n, out_valid && out_data.event_kind == mtep_pkg::EV_ERROR, out_data.status_byte == 8'h00 && out_data.length_value == 32'd0)
  `MTP_ASSERT_IMPL(a_start_tick, clk, rst_n, out_valid && out_data.event_kind == mtep_pkg::EV_START, out_data.tick == 32'd0)
endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_data,
  .out_valid, .out_ready, .out_data
);

FILE: tb/sv/midi_track_event_parser_checker.sv
`timescale 1ns / 1ps

module midi_track_event_parser_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mtep_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mtep_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_events
);
  import mtep_pkg::*;

  localparam logic [7:0] TAG_M = 8'h4D;
  localparam logic [7:0] TAG_T = 8'h54;
  localparam logic [7:0] TAG_R = 8'h72;
  localparam logic [7:0] TAG_K = 8'h6B;

  phase_t      phase;
  logic [1:0]  tag_count;
  logic [31:0] track_left;
  logic [31:0] tick_sum;
  logic [31:0] delta_sum;
  logic [7:0]  running_st;
  logic [7:0]  cur_st;
  logic [7:0]  held_byte;
  logic [7:0]  held_meta;
  logic [31:0] payload_left;
  logic        have_event;
  out_item_t   event_now;
  out_item_t   expected_events[$];

  assign pending_events = expected_events.size();

  function automatic logic [7:0] tag_char(input logic [1:0] idx);
    case (idx)
      2'd0: return TAG_M;
      2'd1: return TAG_T;
      2'd2: return TAG_R;
      default: return TAG_K;
    endcase
  endfunction

  task automatic emit(input logic [3:0] kind, input logic [7:0] st, input logic [7:0] d1,
                      input logic [7:0] d2, input logic [7:0] mt, input logic [31:0] len,
                      input logic [7:0] pb, input logic last);
    event_now = '{kind, tick_sum, st, d1, d2, mt, len, pb, last};
    have_event = 1'b1;
  endtask

  task automatic emit_error();
    emit(EV_ERROR, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0);
  endtask

  task automatic event_done();
    if (track_left == 0) begin
      phase = PH_SEARCH;
    end else begin
      phase = PH_DELTA;
      delta_sum = 0;
    end
  endtask

  task automatic need_more(input phase_t next);
    if (track_left == 0) begin
      emit_error();
      phase = PH_SEARCH;
    end else begin
      phase = next;
    end
  endtask

  task automatic take_delta(input logic [7:0] b);
    delta_sum = (delta_sum << 7) | {25'd0, b[6:0]};
    if (b[7]) begin
      need_more(PH_DELTA);
    end else begin
      tick_sum = tick_sum + delta_sum;
      need_more(PH_STATUS);
    end
  endtask

  task automatic take_channel_first(input logic [7:0] b);
    held_byte = b;
    if (cur_st[7:4] != 4'hC && cur_st[7:4] != 4'hD) begin
      need_more(PH_CH_D2);
    end else begin
      emit(EV_CHANNEL, cur_st, b, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0);
      running_st = cur_st;
      event_done();
    end
  endtask

  task automatic take_length(input logic [7:0] b, input logic is_meta);
    payload_left = (payload_left << 7) | {25'd0, b[6:0]};
    if (b[7]) begin
      need_more(is_meta ? PH_META_LEN : PH_SYSEX_LEN);
    end else begin
      emit(is_meta ? EV_META : EV_SYSEX, cur_st, 8'd0, 8'd0, is_meta ? held_meta : 8'd0,
           payload_left, 8'd0, payload_left == 0);
      if (payload_left == 0) event_done();
      else need_more(PH_PAYLOAD);
    end
  endtask

  task automatic take_status(input logic [7:0] s);
    cur_st = s;
    if (s < ST_SYSEX) begin
      need_more(PH_CH_D1);
    end else if (s == ST_META) begin
      need_more(PH_META_TYPE);
    end else if (s == ST_SYSEX) begin
      running_st = 0;
      payload_left = 0;
      need_more(PH_SYSEX_LEN);
    end else if (s == ST_ESCAPE) begin
      running_st = 0;
      need_more(PH_F7_NEXT);
    end else if (s <= ST_F6) begin
      running_st = 0;
      if (s == ST_F1 || s == ST_F2 || s == ST_F3) begin
        need_more(PH_SC_D1);
      end else begin
        emit(EV_SYSCOM, s, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0);
        event_done();
      end
    end else begin
      if (s != ST_UNDEF) emit(EV_RT, s, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0);
      event_done();
    end
  endtask

  task automatic take_track_byte(input logic [7:0] b);
    track_left = track_left - 1;
    case (phase)
      PH_DELTA: take_delta(b);
      PH_STATUS: begin
        if (b[7]) begin
          take_status(b);
        end else if (running_st[7] && running_st < ST_SYSEX) begin
          cur_st = running_st;
          take_channel_first(b);
        end else begin
          delta_sum = 0;
          take_delta(b);
        end
      end
      PH_CH_D1: take_channel_first(b);
      PH_CH_D2: begin
        emit(EV_CHANNEL, cur_st, held_byte, b, 8'd0, 32'd0, 8'd0, 1'b0);
        running_st = cur_st;
        event_done();
      end
      PH_META_TYPE: begin
        held_meta = b;
        if (b == META_EOT) begin
          need_more(PH_EOT_SKIP);
        end else begin
          payload_left = 0;
          need_more(PH_META_LEN);
        end
      end
      PH_META_LEN: take_length(b, 1'b1);
      PH_SYSEX_LEN: take_length(b, 1'b0);
      PH_EOT_SKIP: begin
        emit(EV_END, ST_META, 8'd0, 8'd0, META_EOT, delta_sum, 8'd0, 1'b0);
        event_done();
      end
      PH_F7_NEXT: begin
        if (b[7]) begin
          take_status(b);
        end else begin
          payload_left = 0;
          take_length(b, 1'b0);
        end
      end
      PH_PAYLOAD: begin
        payload_left = payload_left - 1;
        emit(EV_PAYLOAD, cur_st, 8'd0, 8'd0, cur_st == ST_META ? held_meta : 8'd0, 32'd0,
             b, payload_left == 0);
        if (payload_left == 0) event_done();
        else need_more(PH_PAYLOAD);
      end
      PH_SC_D1: begin
        held_byte = b;
        if (cur_st == ST_F2) begin
          need_more(PH_SC_D2);
        end else begin
          emit(EV_SYSCOM, cur_st, b, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0);
          event_done();
        end
      end
      PH_SC_D2: begin
        emit(EV_SYSCOM, cur_st, held_byte, b, 8'd0, 32'd0, 8'd0, 1'b0);
        event_done();
      end
      default: phase = PH_SEARCH;
    endcase
  endtask

  task automatic predict_byte(input in_item_t req);
    logic [7:0] b;
    b = req.data_byte;
    have_event = 1'b0;
    if (phase == PH_SEARCH) begin
      if (b == tag_char(tag_count)) begin
        if (tag_count == 2'd3) begin
          tag_count = 0;
          track_left = 0;
          phase = PH_LEN0;
        end else begin
          tag_count = tag_count + 1;
        end
      end else begin
        tag_count = (b == TAG_M) ? 2'd1 : 2'd0;
      end
    end else if (phase >= PH_LEN0 && phase <= PH_LEN3) begin
      track_left = (track_left << 8) | {24'd0, b};
      if (phase == PH_LEN3) begin
        tick_sum = 0;
        running_st = 0;
        delta_sum = 0;
        emit(EV_START, 8'd0, 8'd0, 8'd0, 8'd0, track_left, 8'd0, 1'b0);
        phase = (track_left == 0) ? PH_SEARCH : PH_DELTA;
      end else begin
        phase = phase_t'(phase + 1);
      end
    end else begin
      take_track_byte(b);
    end
    if (req.stream_end) begin
      if (phase != PH_SEARCH) emit_error();
      phase = PH_SEARCH;
      tag_count = 0;
    end
    if (have_event) expected_events.push_back(event_now);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      phase = PH_SEARCH;
      tag_count = 0;
      track_left = 0;
      tick_sum = 0;
      delta_sum = 0;
      running_st = 0;
      cur_st = 0;
      held_byte = 0;
      held_meta = 0;
      payload_left = 0;
      expected_events.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report("unexpected event kind", out_data.event_kind, 0);
        end else begin
          want = expected_events.pop_front();
          if (out_data.event_kind != want.event_kind)
            report("event_kind", out_data.event_kind, want.event_kind);
          if (out_data.tick != want.tick) report("tick", out_data.tick, want.tick);
          if (out_data.status_byte != want.status_byte)
            report("status_byte", out_data.status_byte, want.status_byte);
          if (out_data.first_data != want.first_data)
            report("first_data", out_data.first_data, want.first_data);
          if (out_data.second_data != want.second_data)
            report("second_data", out_data.second_data, want.second_data);
          if (out_data.meta_type != want.meta_type)
            report("meta_type", out_data.meta_type, want.meta_type);
          if (out_data.length_value != want.length_value)
            report("length_value", out_data.length_value, want.length_value);
          if (out_data.payload_byte != want.payload_byte)
            report("payload_byte", out_data.payload_byte, want.payload_byte);
          if (out_data.last_of_payload != want.last_of_payload)
            report("last_of_payload", out_data.last_of_payload, want.last_of_payload);
        end
      end
      if (in_valid && in_ready) predict_byte(in_data);
    end
  end

endmodule

FILE: tb/sv/midi_track_event_parser_test.sv
`timescale 1ns / 1ps

module midi_track_event_parser_test;
  import mtep_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_events;
  logic [7:0] song[$];
  int        sent;

  always #10 clk = ~clk;

  midi_track_event_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  midi_track_event_parser_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_events(pending_events)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stalls, with some quiet stretches of steady ready
  initial begin
    int g;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int g;
    g = gap_len();
    if (sent > 600 && sent < 1000) g = 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic push_varlen(input logic [31:0] v);
    logic [7:0] grp[$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (grp[i]) song.push_back(grp[i]);
  endtask

  task automatic push_body_event(input logic running_ok);
    int k;
    int n;
    logic [7:0] s;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      push_varlen($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 300));
    end else begin
      push_varlen($urandom_range(0, 200));
    end
    k = $urandom_range(0, 99);
    if (k < 40) begin
      if (running_ok && $urandom_range(0, 2) == 0) begin
        song.push_back(8'($urandom_range(0, 127)));
      end else begin
        s = 8'($urandom_range(8'h80, 8'hEF));
        song.push_back(s);
        song.push_back(8'($urandom_range(0, 127)));
      end
      song.push_back(8'($urandom_range(0, 127)));
    end else if (k < 55) begin
      song.push_back(ST_META);
      song.push_back($urandom_range(0, 9) == 0 ? 8'h01 : 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 5);
      push_varlen(n);
      repeat (n) song.push_back(8'($urandom));
    end else if (k < 68) begin
      song.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
      n = $urandom_range(0, 5);
      push_varlen(n);
      repeat (n) song.push_back(8'($urandom));
    end else if (k < 80) begin
      song.push_back(8'($urandom_range(8'hF1, 8'hF6)));
      song.push_back(8'($urandom_range(0, 127)));
      song.push_back(8'($urandom_range(0, 127)));
    end else if (k < 92) begin
      song.push_back(8'($urandom_range(8'hF8, 8'hFE)));
    end else if (k < 96) begin
      song.push_back(ST_META);
      song.push_back(META_EOT);
      song.push_back(8'($urandom));
    end else begin
      song.push_back(ST_ESCAPE);
      song.push_back(8'($urandom_range(8'h80, 8'hFF)));
      song.push_back(8'($urandom));
    end
  endtask

  // a track whose length is usually right, sometimes short or long
  task automatic push_track();
    logic [7:0] body[$];
    logic [31:0] len;
    int n;
    int k;
    song.delete();
    n = $urandom_range(1, 8);
    repeat (n) push_body_event(1'b1);
    body = song;
    song.delete();
    if ($urandom_range(0, 3) == 0) song.push_back(8'($urandom));
    song.push_back(8'h4D); song.push_back(8'h54); song.push_back(8'h72); song.push_back(8'h6B);
    len = body.size();
    k = $urandom_range(0, 9);
    if (k == 0 && len > 1) len = len - $urandom_range(1, len - 1);
    else if (k == 1) len = len + $urandom_range(1, 3);
    song.push_back(len[31:24]); song.push_back(len[23:16]);
    song.push_back(len[15:8]); song.push_back(len[7:0]);
    foreach (body[i]) song.push_back(body[i]);
  endtask

  task automatic send_song(input logic end_after);
    foreach (song[i]) send_byte(song[i], end_after && i == song.size() - 1);
  endtask

  initial begin
    logic [7:0] d[$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    sent = 0;

    // directed: broken tag, zero-length track, mixed events, truncation
    d = '{8'h4D, 8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h16,
          8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h00, 8'h7F, 8'h00, 8'h40};
    foreach (d[i]) send_byte(d[i], 1'b0);
    d = '{8'h00, 8'hF2, 8'h7F, 8'h00, 8'h00, 8'hFD, 8'h00, 8'hFE, 8'h00, 8'hF7, 8'hF8,
          8'h00, 8'hF7, 8'h01, 8'hAA, 8'h00, 8'hFF, 8'h2F, 8'hFF};
    foreach (d[i]) send_byte(d[i], i == d.size() - 1);

    // hold until every pending event has come out
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);

    while (sent < 1900) begin
      k_loop: begin
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) begin
          song.delete();
          repeat ($urandom_range(1, 12)) song.push_back(8'($urandom));
          send_song($urandom_range(0, 1));
        end else begin
          push_track();
          send_song(k == 1);
        end
      end
    end
    send_byte(8'h00, 1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** midi_track_event_parser: PASSED **");
    end else begin
      $display("** midi_track_event_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** midi_track_event_parser: FAILED **");
    $finish;
  end

endmodule
